@@ design/smef_pkg.sv @@
// smef_pkg: shared types and constants of the sprite mask edge flagger
// used by smef_front, smef_back and the top module; depends on nothing

package smef_pkg;

   localparam int COORD_W = 5;
   localparam int SIZE_W  = 6;
   localparam int ALPHA_W = 8;
   localparam int ROW_W   = 1 << COORD_W;
   localparam int CSR_W   = 32;

   localparam logic [SIZE_W-1:0]  TILE_SIZE_RESET       = 6'd16;
   localparam logic [ALPHA_W-1:0] ALPHA_THRESHOLD_RESET = 8'd128;

   typedef struct packed {
      logic               pixel_valid;
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic               edge_left;
      logic               edge_right;
      logic               edge_up;
      logic               edge_down;
      logic               tile_done;
   } result_type;

   typedef struct packed {
      logic               pixel_en;
      result_type         pixel;
      logic               flush_en;
      logic [ROW_W-1:0]   row_mask;
      logic [ROW_W-1:0]   above_mask;
      logic [SIZE_W-1:0]  size;
      logic [COORD_W-1:0] row;
   } cmd_type;

endpackage

@@ design/smef_cmd_fifo.sv @@
// smef_cmd_fifo: small flop-based queue of command words between front and back
// generic width and depth; depends on nothing

module smef_cmd_fifo #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty,
   output logic             full
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign rdata   = entries_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

@@ design/smef_front.sv @@
// smef_front: takes alpha words, keeps the row masks and counters, and issues
// one command per word that yields results; depends on smef_pkg

module smef_front #(
   parameter int MAX_TILE_SIZE = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  logic [smef_pkg::ALPHA_W-1:0] req_pixel_alpha,
   input  logic [smef_pkg::SIZE_W-1:0]  tile_size,
   input  logic [smef_pkg::ALPHA_W-1:0] alpha_threshold,
   input  logic                         cmd_full,
   output logic                         cmd_push,
   output smef_pkg::cmd_type            cmd_data
);
   import smef_pkg::*;

   localparam int CW = $clog2(MAX_TILE_SIZE);
   localparam int NW = CW + 1;

   logic [CW-1:0]            col_ff, col_in;
   logic [CW-1:0]            row_ff, row_in;
   logic [MAX_TILE_SIZE-1:0] older_ff, older_in;
   logic [MAX_TILE_SIZE-1:0] prev_ff, prev_in;
   logic [MAX_TILE_SIZE-1:0] cur_ff, cur_in;

   logic                     accept;
   logic                     opaque;
   logic [NW-1:0]            size_n;
   logic [SIZE_W-1:0]        n6;
   logic [COORD_W-1:0]       x_c, y_c, x_dec, x_inc;
   logic [SIZE_W-1:0]        x_next6, y_next6;
   logic                     end_row, end_tile;
   logic [MAX_TILE_SIZE-1:0] cur_next;
   logic [ROW_W-1:0]         cur_ext, prev_ext, older_ext;
   logic                     pixel_en;

   assign full   = cmd_full;
   assign accept = push && !cmd_full;

   always_comb begin
      if (tile_size == '0) begin
         size_n = NW'(1);
      end else if (tile_size > SIZE_W'(MAX_TILE_SIZE)) begin
         size_n = NW'(MAX_TILE_SIZE);
      end else begin
         size_n = NW'(tile_size);
      end
      n6 = SIZE_W'(size_n);

      x_c     = COORD_W'(col_ff);
      y_c     = COORD_W'(row_ff);
      x_dec   = x_c - COORD_W'(1);
      x_inc   = x_c + COORD_W'(1);
      x_next6 = SIZE_W'(x_c) + SIZE_W'(1);
      y_next6 = SIZE_W'(y_c) + SIZE_W'(1);
      end_row  = (x_next6 >= n6);
      end_tile = end_row && (y_next6 >= n6);

      opaque   = (req_pixel_alpha >= alpha_threshold);
      cur_next = cur_ff | ({{(MAX_TILE_SIZE-1){1'b0}}, opaque} << col_ff);

      cur_ext   = ROW_W'(cur_next);
      prev_ext  = ROW_W'(prev_ff);
      older_ext = ROW_W'(older_ff);

      // pixel above the one arriving now
      pixel_en = (y_c != '0) && prev_ext[x_c];

      cmd_data.pixel_en               = pixel_en;
      cmd_data.pixel.pixel_valid      = 1'b1;
      cmd_data.pixel.pixel_x          = x_c;
      cmd_data.pixel.pixel_y          = y_c - COORD_W'(1);
      cmd_data.pixel.edge_left        = (x_c == '0) || !prev_ext[x_dec];
      cmd_data.pixel.edge_right       = end_row || !prev_ext[x_inc];
      cmd_data.pixel.edge_up          = (y_c == COORD_W'(1)) || !older_ext[x_c];
      cmd_data.pixel.edge_down        = !cur_ext[x_c];
      cmd_data.pixel.tile_done        = 1'b0;
      cmd_data.flush_en               = end_tile;
      cmd_data.row_mask               = cur_ext;
      cmd_data.above_mask             = prev_ext;
      cmd_data.size                   = n6;
      cmd_data.row                    = y_c;

      cmd_push = accept && (pixel_en || end_tile);

      col_in   = col_ff;
      row_in   = row_ff;
      older_in = older_ff;
      prev_in  = prev_ff;
      cur_in   = cur_ff;
      if (accept) begin
         if (!end_row) begin
            col_in = col_ff + CW'(1);
            cur_in = cur_next;
         end else if (end_tile) begin
            col_in   = '0;
            row_in   = '0;
            older_in = '0;
            prev_in  = '0;
            cur_in   = '0;
         end else begin
            col_in   = '0;
            row_in   = row_ff + CW'(1);
            older_in = prev_ff;
            prev_in  = cur_next;
            cur_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         older_ff <= '0;
         prev_ff  <= '0;
         cur_ff   <= '0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         older_ff <= older_in;
         prev_ff  <= prev_in;
         cur_ff   <= cur_in;
      end
   end

endmodule

@@ design/smef_back.sv @@
// smef_back: drains commands, walks the final row on a flush, and holds the
// result register; depends on smef_pkg

module smef_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_empty,
   input  smef_pkg::cmd_type     cmd_data,
   output logic                  cmd_pop,
   input  logic                  pop,
   output logic                  empty,
   output smef_pkg::result_type  rsp
);
   import smef_pkg::*;

   typedef enum logic {
      IDLE,
      FLUSH
   } state_type;

   state_type          state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff, rsp_in;
   logic [ROW_W-1:0]   pending_ff, pending_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [ROW_W-1:0]   above_ff, above_in;
   logic [SIZE_W-1:0]  size_ff, size_in;
   logic [COORD_W-1:0] y_ff, y_in;

   logic               out_free;
   logic [ROW_W-1:0]   size_mask;
   logic [COORD_W-1:0] lo_idx, lo_dec, lo_inc;
   logic               lo_any;
   logic [ROW_W-1:0]   rest;

   assign empty = !rsp_valid_ff;
   assign rsp   = rsp_ff;

   always_comb begin
      out_free = !rsp_valid_ff || pop;

      for (int i = 0; i < ROW_W; i++) begin
         size_mask[i] = (SIZE_W'(i) < cmd_data.size);
      end

      // lowest column still to report
      lo_idx = '0;
      for (int i = ROW_W - 1; i >= 0; i--) begin
         if (pending_ff[i]) begin
            lo_idx = COORD_W'(i);
         end
      end
      lo_any = |pending_ff;
      lo_dec = lo_idx - COORD_W'(1);
      lo_inc = lo_idx + COORD_W'(1);
      rest   = pending_ff & ~(ROW_W'(1) << lo_idx);

      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !pop;
      rsp_in       = rsp_ff;
      pending_in   = pending_ff;
      row_in       = row_ff;
      above_in     = above_ff;
      size_in      = size_ff;
      y_in         = y_ff;
      cmd_pop      = 1'b0;

      case (state_ff)
         IDLE: begin
            if (!cmd_empty && out_free) begin
               cmd_pop = 1'b1;
               if (cmd_data.pixel_en) begin
                  rsp_in       = cmd_data.pixel;
                  rsp_valid_in = 1'b1;
               end
               if (cmd_data.flush_en) begin
                  pending_in = cmd_data.row_mask & size_mask;
                  row_in     = cmd_data.row_mask;
                  above_in   = cmd_data.above_mask;
                  size_in    = cmd_data.size;
                  y_in       = cmd_data.row;
                  state_in   = FLUSH;
               end
            end
         end
         FLUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (!lo_any) begin
                  // empty last row: bare end marker
                  rsp_in           = '0;
                  rsp_in.tile_done = 1'b1;
                  state_in         = IDLE;
               end else begin
                  rsp_in.pixel_valid = 1'b1;
                  rsp_in.pixel_x     = lo_idx;
                  rsp_in.pixel_y     = y_ff;
                  rsp_in.edge_left   = (lo_idx == '0) || !row_ff[lo_dec];
                  rsp_in.edge_right  = ((SIZE_W'(lo_idx) + SIZE_W'(1)) >= size_ff)
                                       || !row_ff[lo_inc];
                  rsp_in.edge_up     = (y_ff == '0) || !above_ff[lo_idx];
                  rsp_in.edge_down   = 1'b1;
                  rsp_in.tile_done   = (rest == '0);
                  pending_in         = rest;
                  if (rest == '0) begin
                     state_in = IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
         pending_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pending_ff   <= pending_in;
      end
      rsp_ff   <= rsp_in;
      row_ff   <= row_in;
      above_ff <= above_in;
      size_ff  <= size_in;
      y_ff     <= y_in;
   end

endmodule

@@ design/sprite_mask_edge_flagger.sv @@
// sprite_mask_edge_flagger: one alpha word per cycle in while the command queue
// has room; a pixel result goes via the command queue and result register once
// the word below it is taken. a tile's last word has the back end walk the final
// row, one result per opaque pixel (or an end marker); the front takes next tile
// reset clears masks, counters and queue; tile_size goes to 16, threshold to 128
// depends on smef_pkg, smef_front, smef_cmd_fifo, smef_back

module sprite_mask_edge_flagger #(
   parameter int MAX_TILE_SIZE   = 32,
   parameter int CMD_QUEUE_DEPTH = 2
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic [smef_pkg::ALPHA_W-1:0]   req_pixel_alpha,
   output logic                           empty,
   input  logic                           pop,
   output logic                           rsp_pixel_valid,
   output logic [smef_pkg::COORD_W-1:0]   rsp_pixel_x,
   output logic [smef_pkg::COORD_W-1:0]   rsp_pixel_y,
   output logic                           rsp_edge_left,
   output logic                           rsp_edge_right,
   output logic                           rsp_edge_up,
   output logic                           rsp_edge_down,
   output logic                           rsp_tile_done,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [2:0]                     paddr,
   input  logic [smef_pkg::CSR_W-1:0]     pwdata,
   output logic [smef_pkg::CSR_W-1:0]     prdata,
   output logic                           pready
);
   import smef_pkg::*;

   typedef enum logic {
      REG_TILE_SIZE,
      REG_ALPHA_THRESHOLD
   } csr_index_type;

   logic [SIZE_W-1:0]  tile_size_ff, tile_size_in;
   logic [ALPHA_W-1:0] alpha_threshold_ff, alpha_threshold_in;
   csr_index_type      csr_index;
   logic               csr_write;

   logic               cmd_push, cmd_pop, cmd_empty, cmd_full;
   cmd_type            cmd_wdata, cmd_rdata;
   result_type         rsp;

   assign pready    = 1'b1;
   assign csr_index = csr_index_type'(paddr[2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      tile_size_in       = tile_size_ff;
      alpha_threshold_in = alpha_threshold_ff;
      prdata             = '0;
      case (csr_index)
         REG_TILE_SIZE: begin
            prdata = CSR_W'(tile_size_ff);
            if (csr_write) begin
               tile_size_in = pwdata[SIZE_W-1:0];
            end
         end
         REG_ALPHA_THRESHOLD: begin
            prdata = CSR_W'(alpha_threshold_ff);
            if (csr_write) begin
               alpha_threshold_in = pwdata[ALPHA_W-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_size_ff       <= TILE_SIZE_RESET;
         alpha_threshold_ff <= ALPHA_THRESHOLD_RESET;
      end else begin
         tile_size_ff       <= tile_size_in;
         alpha_threshold_ff <= alpha_threshold_in;
      end
   end

   smef_front #(
      .MAX_TILE_SIZE (MAX_TILE_SIZE)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_pixel_alpha (req_pixel_alpha),
      .tile_size       (tile_size_ff),
      .alpha_threshold (alpha_threshold_ff),
      .cmd_full        (cmd_full),
      .cmd_push        (cmd_push),
      .cmd_data        (cmd_wdata)
   );

   smef_cmd_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMD_QUEUE_DEPTH)
   ) u_cmd_fifo (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata (cmd_wdata),
      .pop   (cmd_pop),
      .rdata (cmd_rdata),
      .empty (cmd_empty),
      .full  (cmd_full)
   );

   smef_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_rdata),
      .cmd_pop   (cmd_pop),
      .pop       (pop),
      .empty     (empty),
      .rsp       (rsp)
   );

   assign rsp_pixel_valid = rsp.pixel_valid;
   assign rsp_pixel_x     = rsp.pixel_x;
   assign rsp_pixel_y     = rsp.pixel_y;
   assign rsp_edge_left   = rsp.edge_left;
   assign rsp_edge_right  = rsp.edge_right;
   assign rsp_edge_up     = rsp.edge_up;
   assign rsp_edge_down   = rsp.edge_down;
   assign rsp_tile_done   = rsp.tile_done;

endmodule
